// File: sv/assert_macros.svh
// Assertion macros used by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk_i edge, off while rst_ni is low.
`define NBBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every rising clk_i edge, off while rst_ni is low.
`define NBBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/nbbst_pkg.sv
// Package: shared constants and item kind codes of the bad block skip table.
`default_nettype none
package nbbst_pkg;

  localparam int unsigned NBBST_MAX_BAD    = 128;
  localparam int unsigned NBBST_BLOCK_BITS = 16;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_XLATE = 2'd2
  } kind_e;

endpackage
`default_nettype wire

// File: sv/nbbst_cell.sv
// One table cell: holds one bad block entry and steps the walker by one entry.
`default_nettype none
module nbbst_cell #(
  parameter int unsigned BLOCK_BITS = 16,
  parameter int unsigned CNT_W      = 8,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // table write and fill level
  input  wire logic                  wr_en_i,
  input  wire logic [BLOCK_BITS-1:0] wr_data_i,
  input  wire logic [CNT_W-1:0]      count_i,
  // walker from the previous cell
  input  wire logic                  tok_i,
  input  wire logic                  go_i,
  input  wire logic [BLOCK_BITS:0]   val_i,
  // walker to the next cell
  output logic                       tok_o,
  output logic                       go_o,
  output logic [BLOCK_BITS:0]        val_o
);

  logic [BLOCK_BITS-1:0] entry_q;
  logic                  tok_q;
  logic                  go_q, go_d;
  logic [BLOCK_BITS:0]   val_q, val_d;
  logic                  used;

  assign used = count_i > CNT_W'(IDX);

  always_comb begin
    go_d  = go_i && used && (val_i >= {1'b0, entry_q});
    val_d = go_d ? val_i + (BLOCK_BITS+1)'(1) : val_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == CNT_W'(IDX))) begin
      entry_q <= wr_data_i;
    end
    go_q  <= go_d;
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;
  assign go_o  = go_q;
  assign val_o = val_q;

endmodule
`default_nettype wire

// File: sv/nand_bad_block_skip_table_unit.sv
// Top level: bad block skip table with scan, fill and translate over a cell chain.
//
// Input stream: each word carries one command. tuser selects the kind: start
// (clear table, scan counter and overflow), scan (one block's bad mark in
// tdata bit 0) or translate (logical block in tdata above bit 0). Output
// stream: exactly one word per command with the physical block (zero unless
// translate), the number of bad blocks held and the overflow status.
// Start, scan and unused kinds give their word in the cycle after acceptance.
// A translate walks the table through a row of MAX_BAD cells, one entry per
// cycle, and its word is registered as the walker leaves the last cell; the
// next command is taken once the word before it has been accepted downstream.
// One command is in flight at a time, so a translate holds off further
// commands until its walk is done.
// A stalled output holds its word and blocks further commands.
// Reset clears the fill count, scan counter and overflow status; the table
// entries themselves are never read beyond the fill count and need no clear.
`default_nettype none
module nand_bad_block_skip_table_unit
  import nbbst_pkg::*;
#(
  parameter int unsigned MAX_BAD    = NBBST_MAX_BAD,
  parameter int unsigned BLOCK_BITS = NBBST_BLOCK_BITS,
  localparam int unsigned CNT_W     = $clog2(MAX_BAD + 1),
  localparam int unsigned IN_DW     = ((BLOCK_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_DW    = ((BLOCK_BITS + CNT_W + 2 + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] is_bad, [BLOCK_BITS:1] logical_block, rest zero
  input  wire logic [IN_DW-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]        s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [BLOCK_BITS:0] physical_block, then bad_count (CNT_W bits), then status, rest zero
  output logic [OUT_DW-1:0]      m_axis_tdata_o
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  localparam int unsigned VW = BLOCK_BITS + 1;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BLOCK_BITS:0] scan_q, scan_d;
  logic               ovf_q, ovf_d;
  logic               out_vld_q;
  logic [VW-1:0]      out_phys_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_ovf_q;

  logic               acc;
  kind_e              kind;
  logic               wr_en;
  logic               tbl_full;
  logic               out_load;

  logic [MAX_BAD:0]   tok;
  logic [MAX_BAD:0]   go;
  logic [VW-1:0]      val [MAX_BAD+1];

  assign kind            = kind_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign tbl_full        = count_q == CNT_W'(MAX_BAD);
  assign out_load        = (acc && (kind != KIND_XLATE)) || tok[MAX_BAD];

  always_comb begin
    count_d = count_q;
    scan_d  = scan_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    if (acc) begin
      case (kind)
        KIND_START: begin
          count_d = '0;
          scan_d  = '0;
          ovf_d   = 1'b0;
        end
        KIND_SCAN: begin
          if (!scan_q[BLOCK_BITS]) begin
            scan_d = scan_q + VW'(1);
            if (s_axis_tdata_i[0]) begin
              if (tbl_full) begin
                ovf_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // walker enters cell 0 on a translate
  assign tok[0] = acc && (kind == KIND_XLATE);
  assign go[0]  = !ovf_q;
  assign val[0] = {1'b0, s_axis_tdata_i[BLOCK_BITS:1]};

  for (genvar i = 0; i < MAX_BAD; i++) begin : g_cell
    nbbst_cell #(
      .BLOCK_BITS(BLOCK_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en),
      .wr_data_i(scan_q[BLOCK_BITS-1:0]),
      .count_i  (count_q),
      .tok_i    (tok[i]),
      .go_i     (go[i]),
      .val_i    (val[i]),
      .tok_o    (tok[i+1]),
      .go_o     (go[i+1]),
      .val_o    (val[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      scan_q     <= '0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_phys_q <= '0;
      out_cnt_q  <= '0;
      out_ovf_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      scan_q  <= scan_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (kind == KIND_XLATE) begin
              state_q <= S_WALK;
            end else begin
              out_phys_q <= '0;
              out_cnt_q  <= count_d;
              out_ovf_q  <= ovf_d;
            end
          end
        end
        S_WALK: begin
          if (tok[MAX_BAD]) begin
            state_q    <= S_IDLE;
            out_phys_q <= val[MAX_BAD];
            out_cnt_q  <= count_q;
            out_ovf_q  <= ovf_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DW'({out_ovf_q, out_cnt_q, out_phys_q});

`include "assert_macros.svh"

  `NBBST_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_BAD), "fill count above table size")
  `NBBST_ASSERT(a_one_walker, $onehot0(tok), "more than one walker in the cell row")
  `NBBST_ASSERT_IMP(a_walk_token, state_q == S_WALK, $onehot(tok), "walk without a walker")
  `NBBST_ASSERT_IMP(a_done_free, tok[MAX_BAD], !out_vld_q, "translate done with output full")

endmodule
`default_nettype wire
